// ===== rtl/core/cfir_pkg.sv =====
// ----------------------------------------------------------------------------
// cfir_pkg: shared definitions for the column FIR filter
// Field widths, register indexes, request codes, sequencer states and the
// control bundle that travels with each multiply-accumulate operation.
// ----------------------------------------------------------------------------
package cfir_pkg;

    // Fixed field widths of the configuration registers and stream fields
    localparam int TF_W       = 6;
    localparam int TL_W       = 5;
    localparam int LEN_W      = 13;
    localparam int DEC_W      = 5;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int COEF_IDX_W = 5;
    localparam int ROW_W      = 13;
    localparam int ROWOUT_W   = 12;

    // Internal widths: tap offsets after clamping, signed row positions,
    // and the bit counter of the row modulo step
    localparam int TAP_W      = 9;
    localparam int YW         = ROW_W + 2;
    localparam int BIT_CNT_W  = 4;

    // Lowest tap offset the filter accepts
    localparam logic signed [TAP_W-1:0] TAP_MIN = -9'sd31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_FIRST     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_LAST      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE      = 3'd4;

    // Configuration reset values
    localparam logic [TF_W-1:0]  TAP_FIRST_RST     = 6'b111001;
    localparam logic [TL_W-1:0]  TAP_LAST_RST      = 5'd7;
    localparam logic [LEN_W-1:0] COLUMN_LENGTH_RST = 13'd4096;
    localparam logic [DEC_W-1:0] DECIMATION_RST    = 5'd1;
    localparam logic             PAD_MODE_RST      = 1'b1;

    // Input request kinds carried in tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // Pad mode codes
    localparam logic PAD_ZERO = 1'b0;
    localparam logic PAD_EDGE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_ROW,
        S_MAC,
        S_WAIT,
        S_EMIT
    } cfir_state_t;

    // Source of the sample operand of one tap
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_FIRST,
        SEL_NEWEST,
        SEL_WIN
    } cfir_sel_t;

    // Control that goes with one multiply-accumulate operation
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } cfir_mac_ctl_t;

endpackage

// ===== rtl/core/cfir_mac.sv =====
// ----------------------------------------------------------------------------
// cfir_mac: shared multiply-accumulate unit
// One signed multiplier with a registered product, a saturating accumulator
// and a round-half-up, saturate stage back to the sample format.
// ----------------------------------------------------------------------------
module cfir_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_TAPS    = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfir_pkg::cfir_mac_ctl_t       ctl,
    input  logic signed [SAMPLE_BITS-1:0] op_a,
    input  logic signed [SAMPLE_BITS-1:0] op_b,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] result
);
    import cfir_pkg::*;

    localparam int FRAC   = SAMPLE_BITS - 1;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int ACC_W  = (SUM_W > 64) ? 64 : SUM_W;
    localparam int QW     = ACC_W - FRAC + 1;

    cfir_mac_ctl_t             ctl1_reg;
    logic                      done_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   prod_ext;
    logic        [ACC_W:0]     sum_w;
    logic signed [QW-1:0]      q_round;
    logic                      q_fits;

    // Product of the two operands
    assign prod_next = op_a * op_b;
    assign prod_ext  = ACC_W'(prod_reg);

    // Saturating accumulate; the first tap of a row loads the product
    always_comb
    begin
        sum_w = {acc_reg[ACC_W-1], acc_reg} + {prod_ext[ACC_W-1], prod_ext};
        if (ctl1_reg.first)
        begin
            acc_next = prod_ext;
        end
        else if (sum_w[ACC_W] != sum_w[ACC_W-1])
        begin
            acc_next = sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                    : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum_w[ACC_W-1:0];
        end
    end

    // Control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl;
            done_reg <= ctl1_reg.valid && ctl1_reg.last;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl1_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // Round half up to the sample format, then saturate
    always_comb
    begin
        q_round = $signed({acc_reg[ACC_W-1], acc_reg[ACC_W-1:FRAC]})
                + $signed({{(QW-1){1'b0}}, acc_reg[FRAC-1]});
        q_fits  = (&q_round[QW-1:SAMPLE_BITS-1]) || !(|q_round[QW-1:SAMPLE_BITS-1]);
        if (q_fits)
        begin
            result = q_round[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = q_round[QW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign done = done_reg;

endmodule

// ===== rtl/core/column_fir_with_edge_padding.sv =====
// ----------------------------------------------------------------------------
// column_fir_with_edge_padding: column FIR filter with border padding
// Filters one image column with a shared multiply-accumulate unit under a
// small sequencer, decimates the output rows and pads above and below.
// Coefficient write beat: the block stays ready.
// Sample beat: the sequencer takes the sample, runs the row modulo step, then for
// each emitted row issues span + 1 taps on the shared multiplier, span = tap_last - tap_first.
// At the column end up to 31 further rows are flushed.
// Reset (rst_n low, asynchronous) clears the sequencer, the row count and the
// coefficient valid bits, so every coefficient reads zero until written.
// ----------------------------------------------------------------------------
module column_fir_with_edge_padding #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_TAPS    = 32,
    parameter int MAX_COLUMN  = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [cfir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cfir_pkg::CFG_W-1:0]          cfg_data,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: sample_in, coef_index, coef_value, zero fill
    input  logic [((2*SAMPLE_BITS+cfir_pkg::COEF_IDX_W+7)/8)*8-1:0] s_tdata,
    // s_tuser: req_type
    input  logic                                s_tuser,
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0: filtered, row_out, zero fill
    output logic [((SAMPLE_BITS+cfir_pkg::ROWOUT_W+7)/8)*8-1:0] m_tdata,
    // m_tlast: column_done
    output logic                                m_tlast
);
    import cfir_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(MAX_TAPS);
    localparam int OUT_W = ((SB + ROWOUT_W + 7) / 8) * 8;

    // Input fields
    logic                        req_type;
    logic signed [SB-1:0]        sample_in;
    logic [COEF_IDX_W-1:0]       coef_index;
    logic signed [SB-1:0]        coef_value;

    // Configuration registers
    logic signed [TF_W-1:0]      tap_first_reg;
    logic [TL_W-1:0]             tap_last_reg;
    logic [LEN_W-1:0]            column_length_reg;
    logic [DEC_W-1:0]            decimation_reg;
    logic                        pad_mode_reg;

    // Effective configuration after clamping
    logic signed [TAP_W-1:0]     tf1;
    logic signed [TAP_W-1:0]     tl1;
    logic signed [TAP_W-1:0]     tf_eff;
    logic signed [TAP_W-1:0]     tl_eff;
    logic signed [TAP_W-1:0]     span_s;
    logic signed [TAP_W-1:0]     max_span;
    logic [AW-1:0]               span_eff;
    logic [ROW_W-1:0]            len_eff;
    logic [DEC_W-1:0]            dec_eff;
    logic signed [YW-1:0]        tf_y;
    logic signed [YW-1:0]        len_y;

    // Sequencer state
    cfir_state_t                 state_reg, state_next;
    logic [ROW_W-1:0]            rows_seen_reg, rows_seen_next;
    logic [AW-1:0]               wp_reg, wp_next;
    logic signed [SB-1:0]        first_reg, first_next;
    logic signed [SB-1:0]        sample_reg, sample_next;
    logic [ROW_W-1:0]            r_reg, r_next;
    logic [AW-1:0]               cur_wp_reg, cur_wp_next;
    logic                        last_reg, last_next;
    logic                        cand_ok_reg, cand_ok_next;
    logic signed [YW-1:0]        y_reg, y_next;
    logic [DEC_W-1:0]            rem_reg, rem_next;
    logic [BIT_CNT_W-1:0]        bit_reg, bit_next;
    logic [DEC_W-1:0]            phase_reg, phase_next;
    logic [AW-1:0]               j_reg, j_next;
    logic signed [YW-1:0]        p_reg, p_next;
    logic [AW-1:0]               slot_reg, slot_next;

    // Tap issue pipeline
    cfir_mac_ctl_t               iss_ctl_reg, iss_ctl_next;
    cfir_sel_t                   sel_reg, sel_next;
    logic signed [SB-1:0]        coef_rd_reg;
    logic                        coef_vrd_reg;
    logic signed [SB-1:0]        win_rd_reg;
    logic [MAX_TAPS-1:0]         coef_vld_reg;

    // Memories
    logic signed [SB-1:0]        coef_mem [MAX_TAPS];
    logic signed [SB-1:0]        win_mem  [MAX_TAPS];

    // Output register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]            out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    // Helpers
    logic                        accept;
    logic                        win_we;
    logic                        coef_we;
    logic [AW-1:0]               coef_addr;
    logic                        last_now;
    logic signed [YW-1:0]        cur_y;
    logic signed [YW-1:0]        r_y;
    logic [DEC_W:0]              rem_tmp;
    logic [DEC_W-1:0]            rem_step;
    logic [DEC_W-1:0]            phase_inc;
    logic [DEC_W-1:0]            phase_adv;
    logic                        row_stop;
    logic                        p_in_win;
    logic                        out_free;
    logic                        col_done;
    logic signed [SB-1:0]        mac_a;
    logic signed [SB-1:0]        mac_b;
    logic                        mac_done;
    logic signed [SB-1:0]        mac_result;

    // Unpack the input beat
    assign req_type   = s_tuser;
    assign sample_in  = s_tdata[SB-1:0];
    assign coef_index = s_tdata[SB+COEF_IDX_W-1:SB];
    assign coef_value = s_tdata[2*SB+COEF_IDX_W-1:SB+COEF_IDX_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign win_we    = accept && (req_type == REQ_SAMPLE);
    assign coef_we   = accept && (req_type == REQ_COEF)
                       && (32'(coef_index) < 32'(MAX_TAPS));
    assign coef_addr = AW'(coef_index);

    // Clamp the tap range, column length and decimation step
    always_comb
    begin
        max_span = $signed(TAP_W'(MAX_TAPS - 1));
        if (!tap_first_reg[TF_W-1] && (tap_first_reg != '0))
        begin
            tf1 = '0;
        end
        else if ($signed({{(TAP_W-TF_W){tap_first_reg[TF_W-1]}}, tap_first_reg}) < TAP_MIN)
        begin
            tf1 = TAP_MIN;
        end
        else
        begin
            tf1 = $signed({{(TAP_W-TF_W){tap_first_reg[TF_W-1]}}, tap_first_reg});
        end
        tl1    = $signed({{(TAP_W-TL_W){1'b0}}, tap_last_reg});
        tf_eff = tf1;
        tl_eff = tl1;
        if ((tl1 - tf1) > max_span)
        begin
            tl_eff = tf1 + max_span;
            if (tl_eff[TAP_W-1])
            begin
                tl_eff = '0;
            end
            if ((tl_eff - tf1) > max_span)
            begin
                tf_eff = tl_eff - max_span;
            end
        end
        span_s   = tl_eff - tf_eff;
        span_eff = span_s[AW-1:0];

        if (column_length_reg == '0)
        begin
            len_eff = ROW_W'(1);
        end
        else if (32'(column_length_reg) > 32'(MAX_COLUMN))
        begin
            len_eff = ROW_W'(MAX_COLUMN);
        end
        else
        begin
            len_eff = column_length_reg;
        end

        dec_eff = (decimation_reg == '0) ? DEC_W'(1) : decimation_reg;
        tf_y    = {{(YW-TAP_W){tf_eff[TAP_W-1]}}, tf_eff};
        len_y   = $signed({{(YW-ROW_W){1'b0}}, len_eff});
    end

    // Shared helper terms of the sequencer
    always_comb
    begin
        last_now  = ({1'b0, rows_seen_reg} + (ROW_W+1)'(1)) >= {1'b0, len_eff};
        cur_y     = $signed({{(YW-ROW_W){1'b0}}, rows_seen_reg}) + tf_y;
        r_y       = $signed({{(YW-ROW_W){1'b0}}, r_reg});
        rem_tmp   = {rem_reg, y_reg[bit_reg]};
        rem_step  = (rem_tmp >= {1'b0, dec_eff}) ? DEC_W'(rem_tmp - {1'b0, dec_eff})
                                                 : rem_tmp[DEC_W-1:0];
        phase_inc = phase_reg + DEC_W'(1);
        phase_adv = (phase_inc == dec_eff) ? '0 : phase_inc;
        row_stop  = !cand_ok_reg || (y_reg >= len_y);
        p_in_win  = !p_reg[YW-1] && (p_reg <= r_y);
        out_free  = !m_tvalid_reg || m_tready;
        col_done  = last_reg
                    && ((y_reg + $signed({{(YW-DEC_W){1'b0}}, dec_eff})) >= len_y);
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        rows_seen_next = rows_seen_reg;
        wp_next        = wp_reg;
        first_next     = first_reg;
        sample_next    = sample_reg;
        r_next         = r_reg;
        cur_wp_next    = cur_wp_reg;
        last_next      = last_reg;
        cand_ok_next   = cand_ok_reg;
        y_next         = y_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        phase_next     = phase_reg;
        j_next         = j_reg;
        p_next         = p_reg;
        slot_next      = slot_reg;
        iss_ctl_next   = '0;
        sel_next       = SEL_ZERO;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (win_we)
                begin
                    // Take the sample, advance the row count and the ring pointer
                    sample_next = sample_in;
                    r_next      = rows_seen_reg;
                    cur_wp_next = wp_reg;
                    last_next   = last_now;
                    if (rows_seen_reg == '0)
                    begin
                        first_next = sample_in;
                    end
                    if (last_now)
                    begin
                        rows_seen_next = '0;
                        wp_next        = '0;
                    end
                    else
                    begin
                        rows_seen_next = rows_seen_reg + ROW_W'(1);
                        wp_next        = (wp_reg == AW'(MAX_TAPS - 1)) ? '0
                                                                       : wp_reg + AW'(1);
                    end
                    // First candidate row is the one this sample completes
                    cand_ok_next = !cur_y[YW-1] || last_now;
                    y_next       = cur_y[YW-1] ? '0 : cur_y;
                    rem_next     = '0;
                    bit_next     = BIT_CNT_W'(ROW_W - 1);
                    state_next   = S_MOD;
                end
            end

            S_MOD:
            begin
                // One bit a cycle of the row modulo the decimation step
                rem_next = rem_step;
                bit_next = bit_reg - BIT_CNT_W'(1);
                if (bit_reg == '0)
                begin
                    phase_next = rem_step;
                    state_next = S_ROW;
                end
            end

            S_ROW:
            begin
                if (row_stop)
                begin
                    state_next = S_IDLE;
                end
                else if (phase_reg == '0)
                begin
                    j_next     = '0;
                    p_next     = y_reg - tf_y;
                    slot_next  = cur_wp_reg;
                    state_next = S_MAC;
                end
                else
                begin
                    // Skipped row: move on to the next one
                    y_next       = y_reg + YW'(1);
                    phase_next   = phase_adv;
                    cand_ok_next = last_reg;
                end
            end

            S_MAC:
            begin
                // Issue one tap: pick the operand source and step the taps
                iss_ctl_next.valid = 1'b1;
                iss_ctl_next.first = (j_reg == '0);
                iss_ctl_next.last  = (j_reg == span_eff);
                if (p_reg[YW-1])
                begin
                    sel_next = (pad_mode_reg == PAD_EDGE) ? SEL_FIRST : SEL_ZERO;
                end
                else if (p_reg > r_y)
                begin
                    sel_next = (pad_mode_reg == PAD_EDGE) ? SEL_NEWEST : SEL_ZERO;
                end
                else
                begin
                    sel_next = SEL_WIN;
                end
                j_next = j_reg + AW'(1);
                p_next = p_reg - YW'(1);
                if (p_in_win)
                begin
                    slot_next = (slot_reg == '0) ? AW'(MAX_TAPS - 1) : slot_reg - AW'(1);
                end
                if (j_reg == span_eff)
                begin
                    state_next = S_WAIT;
                end
            end

            S_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                // Load the result once the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = OUT_W'({y_reg[ROWOUT_W-1:0], mac_result});
                    out_last_next = col_done;
                    y_next        = y_reg + YW'(1);
                    phase_next    = phase_adv;
                    cand_ok_next  = last_reg;
                    state_next    = S_ROW;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            rows_seen_reg     <= '0;
            wp_reg            <= '0;
            first_reg         <= '0;
            iss_ctl_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
            coef_vld_reg      <= '0;
            tap_first_reg     <= TAP_FIRST_RST;
            tap_last_reg      <= TAP_LAST_RST;
            column_length_reg <= COLUMN_LENGTH_RST;
            decimation_reg    <= DECIMATION_RST;
            pad_mode_reg      <= PAD_MODE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rows_seen_reg <= rows_seen_next;
            wp_reg        <= wp_next;
            first_reg     <= first_next;
            iss_ctl_reg   <= iss_ctl_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (coef_we)
            begin
                coef_vld_reg[coef_addr] <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_TAP_FIRST:     tap_first_reg     <= cfg_data[TF_W-1:0];
                    CFG_TAP_LAST:      tap_last_reg      <= cfg_data[TL_W-1:0];
                    CFG_COLUMN_LENGTH: column_length_reg <= cfg_data[LEN_W-1:0];
                    CFG_DECIMATION:    decimation_reg    <= cfg_data[DEC_W-1:0];
                    CFG_PAD_MODE:      pad_mode_reg      <= cfg_data[0];
                    default:           ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        r_reg        <= r_next;
        cur_wp_reg   <= cur_wp_next;
        last_reg     <= last_next;
        cand_ok_reg  <= cand_ok_next;
        y_reg        <= y_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        phase_reg    <= phase_next;
        j_reg        <= j_next;
        p_reg        <= p_next;
        slot_reg     <= slot_next;
        sel_reg      <= sel_next;
        coef_vrd_reg <= coef_vld_reg[j_reg];
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Coefficient memory
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_addr] <= coef_value;
        end
        coef_rd_reg <= coef_mem[j_reg];
    end

    // Sample window ring, indexed by row modulo the tap count
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[wp_reg] <= sample_in;
        end
        win_rd_reg <= win_mem[slot_reg];
    end

    // Operands of the tap issued in the previous cycle
    always_comb
    begin
        case (sel_reg)
            SEL_FIRST:  mac_a = first_reg;
            SEL_NEWEST: mac_a = sample_reg;
            SEL_WIN:    mac_a = win_rd_reg;
            default:    mac_a = '0;
        endcase
        mac_b = coef_vrd_reg ? coef_rd_reg : '0;
    end

    cfir_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (iss_ctl_reg),
        .op_a   (mac_a),
        .op_b   (mac_b),
        .done   (mac_done),
        .result (mac_result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/cfir_checker.sv =====
// ----------------------------------------------------------------------------
// cfir_checker: port-level checks for the column FIR filter
// Watches the stream ports of the top level and is attached by a bind.
// ----------------------------------------------------------------------------
module cfir_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((SAMPLE_BITS+cfir_pkg::ROWOUT_W+7)/8)*8-1:0] m_tdata,
    input logic                                m_tlast
);
    import cfir_pkg::*;

    // A stalled result beat holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // A sample beat starts the sequencer, so the block is busy next cycle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == REQ_SAMPLE) |=> !s_tready)
        else $error("block still ready after a sample beat");

    // A coefficient beat is absorbed at once and the block stays ready
    a_coef_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == REQ_COEF) |=> s_tready)
        else $error("block not ready after a coefficient beat");

    // A new result only appears while a sample is being filtered
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result produced while the sequencer was idle");

endmodule

bind column_fir_with_edge_padding cfir_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cfir_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression bench for column_fir_with_edge_padding
// Drives coefficient and sample beats into the column filter, predicts every
// filtered row with an independent model of taps, padding, rounding,
// saturation and decimation, and checks each output beat in order. A short
// directed part covers the border cases; random phases follow under three
// flow-control profiles.
// ----------------------------------------------------------------------------
module tb;

    import cfir_pkg::*;

    localparam int TAPS            = 32;
    localparam int MAX_ROWS        = 4096;
    localparam int DRAIN_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_BEATS    = 385;

    // Flow-control profiles, applied in this order
    typedef enum logic [1:0] {
        IDLE_SLOW_SINK,
        IDLE_SLOW_SOURCE,
        IDLE_NONE
    } idle_profile_t;

    // One filtered row as it should leave the block
    typedef struct packed {
        logic [15:0] filtered;
        logic [11:0] row_out;
        logic        column_done;
    } column_row_t;

    // Predicts filtered rows from the accepted beats and checks the output
    class column_fir_scoreboard;
        logic signed [15:0] coef_store [TAPS];
        logic signed [15:0] sample_window [TAPS];
        logic signed [15:0] first_sample;
        int                 rows_seen;
        logic [TF_W-1:0]    tap_first_reg;
        logic [TL_W-1:0]    tap_last_reg;
        logic [LEN_W-1:0]   column_length_reg;
        logic [DEC_W-1:0]   decimation_reg;
        logic               pad_reg;
        column_row_t        expected_rows [$];
        int                 errors;

        function new();
            foreach (coef_store[i])
            begin
                coef_store[i] = '0;
                sample_window[i] = '0;
            end
            first_sample = '0;
            rows_seen = 0;
            tap_first_reg = TAP_FIRST_RST;
            tap_last_reg = TAP_LAST_RST;
            column_length_reg = COLUMN_LENGTH_RST;
            decimation_reg = DECIMATION_RST;
            pad_reg = PAD_MODE_RST;
            errors = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_TAP_FIRST:     tap_first_reg = data[TF_W-1:0];
                CFG_TAP_LAST:      tap_last_reg = data[TL_W-1:0];
                CFG_COLUMN_LENGTH: column_length_reg = data[LEN_W-1:0];
                CFG_DECIMATION:    decimation_reg = data[DEC_W-1:0];
                CFG_PAD_MODE:      pad_reg = data[0];
                default:           ;
            endcase
        endfunction

        // Sum of taps for row y, rounded half up to Q1.15 and saturated
        function logic [15:0] row_value(int y, int newest, int tf, int tl);
            longint acc;
            longint operand;
            longint q;
            int     p;
            int     k;
            acc = 0;
            for (k = tf; k <= tl; k++)
            begin
                p = y - k;
                if (p < 0)
                    operand = (pad_reg == PAD_EDGE) ? longint'(first_sample) : 0;
                else if (p > newest)
                    operand = (pad_reg == PAD_EDGE) ?
                              longint'(sample_window[newest % TAPS]) : 0;
                else
                    operand = longint'(sample_window[p % TAPS]);
                acc += operand * longint'(coef_store[k - tf]);
            end
            q = (acc + 64'sd16384) >>> 15;
            if (q > 32767)
                q = 32767;
            else if (q < -32768)
                q = -32768;
            return q[15:0];
        endfunction

        function void note_beat(logic req, logic [15:0] sample_val, logic [4:0] slot,
                                logic [15:0] value);
            int          tf;
            int          tl;
            int          len;
            int          dec;
            int          r;
            int          y;
            int          start;
            bit          ends_column;
            int          due [$];
            column_row_t entry;
            if (req == REQ_COEF)
            begin
                coef_store[slot] = value;
                return;
            end
            // Effective tap range; tf stays at or above -31, so the span cap
            // never pushes tap_last below zero
            tf = $signed(tap_first_reg);
            tl = tap_last_reg;
            if (tf > 0)
                tf = 0;
            if (tf < -31)
                tf = -31;
            if (tl - tf > TAPS - 1)
                tl = tf + TAPS - 1;
            len = column_length_reg;
            if (len < 1)
                len = 1;
            if (len > MAX_ROWS)
                len = MAX_ROWS;
            dec = (decimation_reg == 0) ? 1 : decimation_reg;

            r = rows_seen;
            sample_window[r % TAPS] = sample_val;
            if (r == 0)
                first_sample = sample_val;
            ends_column = (r + 1 >= len);

            // The row that this sample completes, then the flush at column end
            y = r + tf;
            if (y >= 0 && y < len && y % dec == 0)
                due.push_back(y);
            if (ends_column)
            begin
                start = (r + tf + 1 < 0) ? 0 : r + tf + 1;
                for (y = start; y < len; y++)
                    if (y % dec == 0)
                        due.push_back(y);
                rows_seen = 0;
            end
            else
                rows_seen = r + 1;

            foreach (due[i])
            begin
                entry.filtered = row_value(due[i], r, tf, tl);
                entry.row_out = 12'(due[i]);
                entry.column_done = ends_column && (i == due.size() - 1);
                expected_rows.push_back(entry);
            end
        endfunction

        function void check_beat(logic [15:0] filtered, logic [11:0] row_out, logic done);
            column_row_t want;
            if (expected_rows.size() == 0)
            begin
                $error("unexpected output beat: row_out %0d filtered %0d",
                       row_out, $signed(filtered));
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            if (filtered !== want.filtered)
            begin
                $error("filtered: expected %0d, actual %0d",
                       $signed(want.filtered), $signed(filtered));
                errors++;
            end
            if (row_out !== want.row_out)
            begin
                $error("row_out: expected %0d, actual %0d", want.row_out, row_out);
                errors++;
            end
            if (done !== want.column_done)
            begin
                $error("column_done: expected %0b, actual %0b", want.column_done, done);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TAP_FIRST;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata from bit 0: sample_in, coef_index, coef_value, zero fill
    logic [39:0]          s_tdata = '0;
    // s_tuser: req_type
    logic                 s_tuser = REQ_SAMPLE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata from bit 0: filtered, row_out, zero fill
    logic [31:0]          m_tdata;
    // m_tlast: column_done
    logic                 m_tlast;

    idle_profile_t        idle_mode = IDLE_SLOW_SINK;
    int                   quiet_cycles = 0;
    column_fir_scoreboard sb;

    column_fir_with_edge_padding uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Output back-pressure follows the current profile
    always @(negedge clk)
    begin
        case (idle_mode)
            IDLE_SLOW_SINK:   m_tready = ($urandom_range(0, 99) >= 75);
            IDLE_SLOW_SOURCE: m_tready = ($urandom_range(0, 99) >= 21);
            default:          m_tready = 1'b1;
        endcase
    end

    // Check every accepted output beat
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata[15:0], m_tdata[27:16], m_tlast);
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("column_fir_with_edge_padding regression: fail");
            $finish;
        end
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SLOW_SINK:   return $urandom_range(0, 99) < 21;
            IDLE_SLOW_SOURCE: return $urandom_range(0, 99) < 75;
            default:          return 1'b0;
        endcase
    endfunction

    // Full-scale extremes, full-range random values or small values, a third each
    function automatic logic [15:0] random_q15();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    // Presents one beat from a falling edge and returns at the falling edge
    // after it is taken; tvalid stays high for a following beat
    task automatic send_beat(logic req, logic [15:0] sample_val, logic [4:0] slot,
                             logic [15:0] value);
        while (sender_idles())
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = req;
        s_tdata = {3'b000, value, slot, sample_val};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(req, sample_val, slot, value);
        @(negedge clk);
    endtask

    task automatic send_sample(logic [15:0] sample_val);
        send_beat(REQ_SAMPLE, sample_val, 5'($urandom), 16'($urandom));
    endtask

    task automatic send_coef(logic [4:0] slot, logic [15:0] value);
        send_beat(REQ_COEF, 16'($urandom), slot, value);
    endtask

    task automatic register_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        sb.write_register(idx, data);
        @(negedge clk);
    endtask

    // Writes the registers selected by mask, bit 0 being tap_first
    task automatic configure(logic [4:0] mask, logic [CFG_W-1:0] tf, logic [CFG_W-1:0] tl,
                             logic [CFG_W-1:0] len, logic [CFG_W-1:0] dec, logic pad);
        if (mask[0])
            register_beat(CFG_TAP_FIRST, tf);
        if (mask[1])
            register_beat(CFG_TAP_LAST, tl);
        if (mask[2])
            register_beat(CFG_COLUMN_LENGTH, len);
        if (mask[3])
            register_beat(CFG_DECIMATION, dec);
        if (mask[4])
            register_beat(CFG_PAD_MODE, CFG_W'(pad));
        cfg_wr_en = 1'b0;
    endtask

    // Waits until every predicted row has left and the block has gone quiet
    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // One random register setting followed by a run of beats
    task automatic random_phase(int beats);
        logic [CFG_W-1:0] tf;
        logic [CFG_W-1:0] tl;
        logic [CFG_W-1:0] len;
        logic [CFG_W-1:0] dec;
        logic             pad;
        int               lead;
        int               i;
        case ($urandom_range(0, 7))
            0:       tf = CFG_W'($urandom_range(0, 63));
            1:       tf = CFG_W'(-31);
            2:       tf = '0;
            default: tf = CFG_W'(-int'($urandom_range(0, 8)));
        endcase
        case ($urandom_range(0, 5))
            0:       tl = CFG_W'(31);
            1:       tl = CFG_W'($urandom_range(0, 31));
            default: tl = CFG_W'($urandom_range(0, 8));
        endcase
        // Long columns only end when a later phase lowers the length
        case ($urandom_range(0, 11))
            0:       len = '0;
            1:       len = CFG_W'(MAX_ROWS);
            2:       len = '1;
            3:       len = CFG_W'($urandom);
            default: len = CFG_W'($urandom_range(1, 20));
        endcase
        case ($urandom_range(0, 9))
            0:       dec = '0;
            1:       dec = CFG_W'(16);
            2:       dec = CFG_W'(31);
            3:       dec = CFG_W'($urandom_range(0, 31));
            default: dec = CFG_W'($urandom_range(1, 3));
        endcase
        pad = $urandom_range(0, 1) ? PAD_EDGE : PAD_ZERO;
        configure(5'($urandom), tf, tl, len, dec, pad);

        lead = $urandom_range(0, 4);
        for (i = 0; i < beats; i++)
        begin
            if (i < lead || $urandom_range(0, 99) < 8)
                send_coef(5'($urandom), random_q15());
            else
                send_sample(random_q15());
        end
        settle();
    endtask

    initial
    begin
        int sent;
        int beats;
        sb = new();
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Coefficients at the slot extremes under the reset taps
        send_coef(5'd0, 16'h7FFF);
        send_coef(5'd31, 16'h8000);
        send_coef(5'd7, 16'h4000);
        settle();

        // Five-row column with edge repeat: top and bottom padding, full-scale
        // samples driving the sum into saturation
        configure(5'b11111, CFG_W'(-2), CFG_W'(2), CFG_W'(5), CFG_W'(1), PAD_EDGE);
        send_coef(5'd2, 16'h8000);
        send_coef(5'd4, 16'd12345);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        settle();

        // Positive tap_first, zero length and zero decimation: every sample
        // is a one-row column under zero padding
        configure(5'b11111, CFG_W'(31), CFG_W'(31), '0, '0, PAD_ZERO);
        send_sample(16'h1234);
        send_sample(16'h8001);
        send_sample(16'h7FFE);
        settle();

        // Span too wide and length above the maximum; the length is lowered
        // mid column so the next sample ends it
        configure(5'b11111, CFG_W'(-32), CFG_W'(31), '1, CFG_W'(3), PAD_EDGE);
        send_sample(16'h4000);
        send_sample(16'hC000);
        send_sample(16'h00FF);
        send_sample(16'hFF00);
        settle();
        configure(5'b00100, '0, '0, CFG_W'(2), '0, PAD_EDGE);
        send_sample(16'h2AAA);
        settle();

        // Column end on a row that decimation drops: no beat carries tlast
        configure(5'b11111, '0, CFG_W'(3), CFG_W'(5), CFG_W'(3), PAD_ZERO);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h0F0F);
        send_sample(16'hF0F0);
        send_sample(16'h3333);
        settle();

        // Random phases under each flow-control profile in turn
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            if (sent >= 2 * RANDOM_BEATS / 3)
                idle_mode = IDLE_NONE;
            else if (sent >= RANDOM_BEATS / 3)
                idle_mode = IDLE_SLOW_SOURCE;
            beats = $urandom_range(6, 40);
            random_phase(beats);
            sent += beats;
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("column_fir_with_edge_padding regression: pass");
        else
            $display("column_fir_with_edge_padding regression: fail");
        $finish;
    end

endmodule
